// ----- rtl/sdm_pkg.sv -----
`timescale 1ns / 1ps

package sdm_pkg;

    // Dictionary and history sizes
    localparam int MAX_NODES = 1024;
    localparam int MAX_LEN   = 32;
    localparam int ALPHABET  = 26;

    // Derived widths
    localparam int LETTER_W = 5;
    localparam int NODE_W   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int NCNT_W   = $clog2(MAX_NODES + 1);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int POS_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // One trie row: a child link per letter plus the word end mark on top
    localparam int ROW_W    = ALPHABET * NODE_W + 1;
    localparam int MARK_BIT = ROW_W - 1;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_LONG = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [LETTER_W-1:0] letter;
        logic                word_end;
    } in_item_t;

    typedef struct packed {
        logic       match;
        logic [1:0] status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic init_row;
        logic take;
        logic ins_decide;
        logic ins_new;
        logic mark_read;
        logic mark_write;
        logic walk_step;
        logic resp_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_query;
        logic dec_new;
        logic dec_mark;
        logic walk_done;
        logic out_free;
    } sts_t;

    function automatic logic letter_ok(input logic [LETTER_W-1:0] c);
        return int'(c) < ALPHABET;
    endfunction

    function automatic logic [NODE_W-1:0] get_link(input logic [ROW_W-1:0] row,
                                                  input logic [LETTER_W-1:0] c);
        return row[int'(c) * NODE_W +: NODE_W];
    endfunction

    function automatic logic [ROW_W-1:0] set_link(input logic [ROW_W-1:0] row,
                                                 input logic [LETTER_W-1:0] c,
                                                 input logic [NODE_W-1:0] id);
        logic [ROW_W-1:0] r;
        r = row;
        r[int'(c) * NODE_W +: NODE_W] = id;
        return r;
    endfunction

endpackage

// ----- rtl/sdm_ctrl.sv -----
`timescale 1ns / 1ps

module sdm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sdm_pkg::sts_t sts,
    output sdm_pkg::cmd_t cmd
);
    import sdm_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT    = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_INS_DEC = 8'b0000_0100,
        ST_INS_NEW = 8'b0000_1000,
        ST_MARK_RD = 8'b0001_0000,
        ST_MARK_WR = 8'b0010_0000,
        ST_WALK    = 8'b0100_0000,
        ST_RESP    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Sequence one transaction at a time through the datapath
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_row = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = sts.in_query ? ST_WALK : ST_INS_DEC;
                end
            end
            ST_INS_DEC: begin
                cmd.ins_decide = 1'b1;
                if (sts.dec_new) begin
                    state_next = ST_INS_NEW;
                end else if (sts.dec_mark) begin
                    state_next = ST_MARK_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_INS_NEW: begin
                cmd.ins_new = 1'b1;
                state_next  = ST_RESP;
            end
            ST_MARK_RD: begin
                cmd.mark_read = 1'b1;
                state_next    = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.mark_write = 1'b1;
                state_next     = ST_RESP;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.resp_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/sdm_dp.sv -----
`timescale 1ns / 1ps

module sdm_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  sdm_pkg::in_item_t  s_item,
    input  sdm_pkg::cmd_t      cmd,
    output sdm_pkg::sts_t      sts,
    input  logic               m_ready,
    output logic               m_valid,
    output sdm_pkg::out_item_t m_item
);
    import sdm_pkg::*;

    // Trie rows and recent letters
    logic [ROW_W-1:0]    row_mem [MAX_NODES];
    logic [LETTER_W-1:0] hist_mem [MAX_LEN];

    logic [ROW_W-1:0]    rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [NODE_W-1:0]   mem_waddr;
    logic [NODE_W-1:0]   mem_raddr;
    logic [ROW_W-1:0]    mem_wdata;
    logic                hist_we;
    logic                hist_re;
    logic [LETTER_W-1:0] hist_rdata_reg;

    in_item_t            item_reg, item_next;
    logic [NCNT_W-1:0]   nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [LEN_W-1:0]    depth_reg, depth_next;
    logic                dropping_reg, dropping_next;
    logic [NODE_W-1:0]   child_reg, child_next;
    logic [POS_W-1:0]    head_reg, head_next;
    logic [LEN_W-1:0]    fill_reg, fill_next;
    logic [LEN_W-1:0]    walk_idx_reg, walk_idx_next;
    logic [POS_W-1:0]    walk_pos_reg, walk_pos_next;
    logic                res_match_reg, res_match_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg, m_item_next;

    logic [POS_W-1:0]    head_step;
    logic [POS_W-1:0]    pos_step;
    logic                dec_letter_ok;
    logic                dec_long;
    logic                dec_skip;
    logic [NODE_W-1:0]   dec_link;
    logic                dec_full;
    logic                dec_alloc;
    logic [NODE_W-1:0]   new_id;
    logic [LETTER_W-1:0] w_letter;
    logic                w_ok;
    logic [NODE_W-1:0]   w_link;
    logic                w_hit;
    logic                w_end;
    logic                w_done;

    // Ring pointers
    assign head_step = (head_reg == POS_W'(MAX_LEN - 1)) ? '0 : head_reg + POS_W'(1);
    assign pos_step  = (walk_pos_reg == '0) ? POS_W'(MAX_LEN - 1) : walk_pos_reg - POS_W'(1);

    // Insert decision on the cursor row
    assign dec_letter_ok = letter_ok(item_reg.letter);
    assign dec_long      = depth_reg >= LEN_W'(MAX_LEN);
    assign dec_skip      = dropping_reg || !dec_letter_ok || dec_long;
    assign dec_link      = dec_letter_ok ? get_link(rdata_reg, item_reg.letter) : '0;
    assign dec_full      = !dec_skip && (dec_link == '0) && (nodes_used_reg == NCNT_W'(MAX_NODES));
    assign dec_alloc     = !dec_skip && (dec_link == '0) && !dec_full;
    assign new_id        = nodes_used_reg[NODE_W-1:0];

    // Walk step on the current node row
    assign w_letter = hist_rdata_reg;
    assign w_ok     = letter_ok(w_letter);
    assign w_link   = w_ok ? get_link(rdata_reg, w_letter) : '0;
    assign w_hit    = (walk_idx_reg != '0) && rdata_reg[MARK_BIT];
    assign w_end    = (walk_idx_reg == fill_reg);
    assign w_done   = w_hit || w_end || !w_ok || (w_link == '0);

    assign sts.in_query  = (s_item.operation == OP_QUERY);
    assign sts.dec_new   = dec_alloc;
    assign sts.dec_mark  = !dec_skip && (dec_link != '0) && item_reg.word_end;
    assign sts.walk_done = w_done;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Next state of the datapath registers and the memory port controls
    always_comb begin
        item_next       = item_reg;
        nodes_used_next = nodes_used_reg;
        cursor_next     = cursor_reg;
        depth_next      = depth_reg;
        dropping_next   = dropping_reg;
        child_next      = child_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        walk_idx_next   = walk_idx_reg;
        walk_pos_next   = walk_pos_reg;
        res_match_next  = res_match_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = child_reg;
        mem_wdata       = rdata_reg;
        mem_re          = 1'b0;
        mem_raddr       = cursor_reg;
        hist_we         = 1'b0;
        hist_re         = 1'b0;

        // Clear the root row after reset
        if (cmd.init_row) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '0;
        end

        // Latch the transaction and fetch the first row
        if (cmd.take) begin
            item_next       = s_item;
            res_match_next  = 1'b0;
            res_status_next = STATUS_OK;
            mem_re          = 1'b1;
            if (s_item.operation == OP_QUERY) begin
                head_next     = head_step;
                hist_we       = 1'b1;
                if (fill_reg < LEN_W'(MAX_LEN)) begin
                    fill_next = fill_reg + LEN_W'(1);
                end
                walk_idx_next = '0;
                walk_pos_next = head_step;
                mem_raddr     = '0;
            end else begin
                mem_raddr = cursor_reg;
            end
        end

        // Follow or create the child link
        if (cmd.ins_decide) begin
            if (dec_skip) begin
                if (!dropping_reg) begin
                    dropping_next = 1'b1;
                    if (dec_letter_ok) begin
                        res_status_next = STATUS_LONG;
                    end
                end
            end else if (dec_link != '0) begin
                cursor_next = dec_link;
                depth_next  = depth_reg + LEN_W'(1);
                child_next  = dec_link;
            end else if (dec_full) begin
                dropping_next   = 1'b1;
                res_status_next = STATUS_FULL;
            end else begin
                mem_we          = 1'b1;
                mem_waddr       = cursor_reg;
                mem_wdata       = set_link(rdata_reg, item_reg.letter, new_id);
                nodes_used_next = nodes_used_reg + NCNT_W'(1);
                cursor_next     = new_id;
                depth_next      = depth_reg + LEN_W'(1);
                child_next      = new_id;
            end
            if (item_reg.word_end && !sts.dec_new && !sts.dec_mark) begin
                cursor_next   = '0;
                depth_next    = '0;
                dropping_next = 1'b0;
            end
        end

        // Initialize the new node row, marked if the word ends here
        if (cmd.ins_new) begin
            mem_we              = 1'b1;
            mem_waddr           = child_reg;
            mem_wdata           = '0;
            mem_wdata[MARK_BIT] = item_reg.word_end;
            if (item_reg.word_end) begin
                cursor_next   = '0;
                depth_next    = '0;
                dropping_next = 1'b0;
            end
        end

        // Mark an existing node as a word end
        if (cmd.mark_read) begin
            mem_re    = 1'b1;
            mem_raddr = child_reg;
        end
        if (cmd.mark_write) begin
            mem_we              = 1'b1;
            mem_waddr           = child_reg;
            mem_wdata           = rdata_reg;
            mem_wdata[MARK_BIT] = 1'b1;
            cursor_next         = '0;
            depth_next          = '0;
            dropping_next       = 1'b0;
        end

        // Advance the walk one node back through the history
        if (cmd.walk_step) begin
            if (w_done) begin
                res_match_next = w_hit;
            end else begin
                mem_re        = 1'b1;
                mem_raddr     = w_link;
                hist_re       = 1'b1;
                walk_idx_next = walk_idx_reg + LEN_W'(1);
                walk_pos_next = pos_step;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (cmd.resp_load) begin
            m_valid_next       = 1'b1;
            m_item_next.match  = res_match_reg;
            m_item_next.status = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Trie memory with registered read, history ring
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= row_mem[mem_raddr];
        end
        if (hist_we) begin
            hist_mem[head_step] <= s_item.letter;
        end
        // Registered history read; pass the newest letter straight through
        if (hist_we) begin
            hist_rdata_reg <= s_item.letter;
        end else if (hist_re) begin
            hist_rdata_reg <= hist_mem[pos_step];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodes_used_reg <= NCNT_W'(1);
            cursor_reg     <= '0;
            depth_reg      <= '0;
            dropping_reg   <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            nodes_used_reg <= nodes_used_next;
            cursor_reg     <= cursor_next;
            depth_reg      <= depth_next;
            dropping_reg   <= dropping_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        child_reg      <= child_next;
        walk_idx_reg   <= walk_idx_next;
        walk_pos_reg   <= walk_pos_next;
        res_match_reg  <= res_match_next;
        res_status_reg <= res_status_next;
        m_item_reg     <= m_item_next;
    end

endmodule

// ----- rtl/stream_suffix_dictionary_match_core.sv -----
// Channel   Ports                         Payload
// input     s_valid / s_ready / s_item    operation, letter, word_end
// result    m_valid / m_ready / m_item    match, status
//
// One transaction at a time. Insert runs ST_INS_DEC, plus ST_INS_NEW when a node
// is created or ST_MARK_RD, ST_MARK_WR when an existing node gets a word end
// mark, then ST_RESP. Query runs ST_WALK, bounded by fill and ending early when
// the walk dies, then ST_RESP; one node per cycle, set by the trie row memory's
// single read port. After reset the root row is cleared in ST_INIT with s_ready
// low. A result waits in the output register until taken before the next loads.
`timescale 1ns / 1ps

module stream_suffix_dictionary_match_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sdm_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sdm_pkg::out_item_t m_item
);
    import sdm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sdm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule

// ----- rtl/sdm_checker.sv -----
`timescale 1ns / 1ps

module sdm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input sdm_pkg::out_item_t m_item
);
    import sdm_pkg::*;

    // Reset empties the output and holds off input during the root clear
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output valid or input ready right after reset");

    // One transaction in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // Stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // A match never comes with an error status, and status is a known code
    a_result_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.status == STATUS_OK)
                 || (!m_item.match && (m_item.status == STATUS_FULL
                                       || m_item.status == STATUS_LONG)))
        else $error("bad result code");

endmodule

bind stream_suffix_dictionary_match_core sdm_checker u_sdm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
